### hdl/cbt_pkg.sv
// ----------------------------------------------------------------------------
// cbt_pkg
// Shared widths, constants and types of the cubic Bezier tessellator.
// ----------------------------------------------------------------------------
package cbt_pkg;

	localparam int MAX_SAMPLES   = 64;
	localparam int MIN_SAMPLES   = 2;
	localparam int RESET_SAMPLES = 16;
	localparam int COORD_BITS    = 32;

	localparam int CFG_W = 7;
	localparam int N_W   = $clog2(MAX_SAMPLES + 1);
	localparam int S_W   = $clog2(MAX_SAMPLES);
	localparam int FRAC  = 16;
	localparam int T_W   = FRAC;
	localparam int U_W   = FRAC + 1;
	localparam int A_W   = U_W + 1;
	localparam int W_W   = FRAC + 1;

	localparam int PROD_W = COORD_BITS + W_W + 1;
	localparam int SUM_W  = PROD_W + 2;
	localparam int SH_W   = SUM_W - FRAC;

	localparam int DIV_STEPS = FRAC + 1;
	localparam int DIVC_W    = $clog2(DIV_STEPS);

	localparam int RESET_Q = (1 << FRAC) / RESET_SAMPLES;
	localparam int RESET_R = (1 << FRAC) % RESET_SAMPLES;

	localparam logic [U_W-1:0] ONE_Q16 = {1'b1, {FRAC{1'b0}}};

	typedef logic signed [COORD_BITS-1:0] coord_t;

	localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS - 1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS - 1){1'b0}}};

	typedef struct packed {
		coord_t [3:0] x;
		coord_t [3:0] y;
	} seg_t;

	typedef struct packed {
		logic           last;
		logic [T_W-1:0] t;
		logic [U_W-1:0] u;
		seg_t           pts;
	} sample_t;

endpackage

### hdl/cbt_seg_if.sv
// ----------------------------------------------------------------------------
// cbt_seg_if
// Segment channel: four control points per transaction.
// ----------------------------------------------------------------------------
interface cbt_seg_if;
	logic            valid;
	logic            ready;
	cbt_pkg::coord_t start_x;
	cbt_pkg::coord_t start_y;
	cbt_pkg::coord_t handle_out_x;
	cbt_pkg::coord_t handle_out_y;
	cbt_pkg::coord_t handle_in_x;
	cbt_pkg::coord_t handle_in_y;
	cbt_pkg::coord_t end_x;
	cbt_pkg::coord_t end_y;

	modport source (
		output valid, start_x, start_y, handle_out_x, handle_out_y,
		output handle_in_x, handle_in_y, end_x, end_y,
		input  ready
	);
	modport sink (
		input  valid, start_x, start_y, handle_out_x, handle_out_y,
		input  handle_in_x, handle_in_y, end_x, end_y,
		output ready
	);
endinterface

### hdl/cbt_pt_if.sv
// ----------------------------------------------------------------------------
// cbt_pt_if
// Point channel: one sampled curve point per transaction.
// ----------------------------------------------------------------------------
interface cbt_pt_if;
	logic            valid;
	logic            ready;
	cbt_pkg::coord_t point_x;
	cbt_pkg::coord_t point_y;
	logic            last_sample;

	modport source (output valid, point_x, point_y, last_sample, input ready);
	modport sink (input valid, point_x, point_y, last_sample, output ready);
endinterface

### hdl/cbt_eval.sv
// ----------------------------------------------------------------------------
// cbt_eval
// Seven-stage Bernstein evaluation pipeline: weights, products, sum, saturate.
// ----------------------------------------------------------------------------
module cbt_eval (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              in_vld,
	input  cbt_pkg::sample_t  in_smp,
	output logic              out_vld,
	output cbt_pkg::coord_t   out_x,
	output cbt_pkg::coord_t   out_y,
	output logic              out_last
);

	function automatic logic signed [cbt_pkg::SUM_W-1:0] sext_prod(
		input logic signed [cbt_pkg::PROD_W-1:0] v
	);
		return {{(cbt_pkg::SUM_W - cbt_pkg::PROD_W){v[cbt_pkg::PROD_W-1]}}, v};
	endfunction

	function automatic cbt_pkg::coord_t sat_coord(
		input logic [cbt_pkg::SH_W-1:0] v
	);
		logic [cbt_pkg::SH_W-cbt_pkg::COORD_BITS:0] top;
		top = v[cbt_pkg::SH_W-1:cbt_pkg::COORD_BITS-1];
		if ((&top) || !(|top))
			return v[cbt_pkg::COORD_BITS-1:0];
		else if (v[cbt_pkg::SH_W-1])
			return cbt_pkg::COORD_MIN;
		else
			return cbt_pkg::COORD_MAX;
	endfunction

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic last_s1, last_s2, last_s3, last_s4, last_s5, last_s6;

	logic [cbt_pkg::T_W-1:0] t_s1, t_s2;
	logic [cbt_pkg::U_W-1:0] u_s1, u_s2;
	cbt_pkg::seg_t pts_s1, pts_s2, pts_s3;

	logic [2*cbt_pkg::U_W-1:0]           uu_s1;
	logic [cbt_pkg::U_W+cbt_pkg::T_W-1:0] ut_s1;
	logic [2*cbt_pkg::T_W-1:0]           tt_s1;

	logic [cbt_pkg::U_W-1:0] a0_s2;
	logic [cbt_pkg::A_W-1:0] a1_s2, a2_s2;
	logic [cbt_pkg::T_W-1:0] a3_s2;

	logic [2*cbt_pkg::U_W+1:0]            uu3;
	logic [cbt_pkg::U_W+cbt_pkg::T_W+1:0] ut3;
	logic [2*cbt_pkg::U_W-1:0]            p0, p1, p2, p3;

	logic [cbt_pkg::W_W-1:0] w_s3 [4];

	logic signed [cbt_pkg::PROD_W-1:0] px_s4 [4];
	logic signed [cbt_pkg::PROD_W-1:0] py_s4 [4];
	logic signed [cbt_pkg::SUM_W-1:0]  sx_s5 [2];
	logic signed [cbt_pkg::SUM_W-1:0]  sy_s5 [2];
	logic signed [cbt_pkg::SUM_W-1:0]  sx_s6, sy_s6;

	assign uu3 = ({2'b00, uu_s1} << 1) + {2'b00, uu_s1};
	assign ut3 = ({2'b00, ut_s1} << 1) + {2'b00, ut_s1};

	assign p0 = a0_s2 * u_s2;
	assign p1 = a1_s2 * t_s2;
	assign p2 = a2_s2 * t_s2;
	assign p3 = a3_s2 * t_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			out_vld <= 1'b0;
		end else if (adv) begin
			vld_s1  <= in_vld;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			out_vld <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s1 <= in_smp.last;
			t_s1    <= in_smp.t;
			u_s1    <= in_smp.u;
			pts_s1  <= in_smp.pts;
			uu_s1   <= in_smp.u * in_smp.u;
			ut_s1   <= in_smp.u * in_smp.t;
			tt_s1   <= in_smp.t * in_smp.t;

			last_s2 <= last_s1;
			t_s2    <= t_s1;
			u_s2    <= u_s1;
			pts_s2  <= pts_s1;
			a0_s2   <= uu_s1[cbt_pkg::FRAC+cbt_pkg::U_W-1:cbt_pkg::FRAC];
			a1_s2   <= uu3[cbt_pkg::FRAC+cbt_pkg::A_W-1:cbt_pkg::FRAC];
			a2_s2   <= ut3[cbt_pkg::FRAC+cbt_pkg::A_W-1:cbt_pkg::FRAC];
			a3_s2   <= tt_s1[2*cbt_pkg::T_W-1:cbt_pkg::FRAC];

			last_s3 <= last_s2;
			pts_s3  <= pts_s2;
			w_s3[0] <= p0[cbt_pkg::FRAC+cbt_pkg::W_W-1:cbt_pkg::FRAC];
			w_s3[1] <= p1[cbt_pkg::FRAC+cbt_pkg::W_W-1:cbt_pkg::FRAC];
			w_s3[2] <= p2[cbt_pkg::FRAC+cbt_pkg::W_W-1:cbt_pkg::FRAC];
			w_s3[3] <= p3[cbt_pkg::FRAC+cbt_pkg::W_W-1:cbt_pkg::FRAC];

			last_s4 <= last_s3;
			for (int k = 0; k < 4; k++) begin
				px_s4[k] <= $signed(pts_s3.x[k]) * $signed({1'b0, w_s3[k]});
				py_s4[k] <= $signed(pts_s3.y[k]) * $signed({1'b0, w_s3[k]});
			end

			last_s5  <= last_s4;
			sx_s5[0] <= sext_prod(px_s4[0]) + sext_prod(px_s4[1]);
			sx_s5[1] <= sext_prod(px_s4[2]) + sext_prod(px_s4[3]);
			sy_s5[0] <= sext_prod(py_s4[0]) + sext_prod(py_s4[1]);
			sy_s5[1] <= sext_prod(py_s4[2]) + sext_prod(py_s4[3]);

			last_s6 <= last_s5;
			sx_s6   <= sx_s5[0] + sx_s5[1];
			sy_s6   <= sy_s5[0] + sy_s5[1];

			out_last <= last_s6;
			out_x    <= sat_coord(sx_s6[cbt_pkg::SUM_W-1:cbt_pkg::FRAC]);
			out_y    <= sat_coord(sy_s6[cbt_pkg::SUM_W-1:cbt_pkg::FRAC]);
		end
	end

endmodule

### hdl/cubic_bezier_tessellator.sv
// ----------------------------------------------------------------------------
// cubic_bezier_tessellator: throughput one point per cycle while the point channel
// does not stall, N points per segment (N = clamped count), set by the sample counter
// that steps t once per issued sample into the evaluation pipeline. Reset clears all
// valids and sets the count to 16; a count write holds the segment channel off while
// the t step is divided out, one bit per cycle.
// ----------------------------------------------------------------------------
module cubic_bezier_tessellator (
	input  logic                      clk,
	input  logic                      arst_n,
	cbt_seg_if.sink                   segment,
	cbt_pt_if.source                  point,
	input  logic                      wr_en,
	input  logic [cbt_pkg::CFG_W-1:0] wr_data
);

	logic [cbt_pkg::N_W-1:0] n_q, n_new;
	logic [cbt_pkg::T_W-1:0] q_q;
	logic [cbt_pkg::S_W-1:0] r_q;

	logic                          busy_q;
	logic [cbt_pkg::DIVC_W-1:0]    cnt_q;
	logic [cbt_pkg::S_W-1:0]       drem_q;
	logic [cbt_pkg::DIV_STEPS-1:0] quo_q, quo_nxt;
	logic                          div_bit, div_ge;
	logic [cbt_pkg::S_W:0]         div_sh, div_rem;

	cbt_pkg::seg_t           seg_q, seg_d;
	logic                    seg_vld_q;
	logic [cbt_pkg::S_W-1:0] s_q;
	logic [cbt_pkg::T_W-1:0] t_q, t_nxt;
	logic [cbt_pkg::U_W-1:0] u_q, u_nxt;
	logic [cbt_pkg::S_W-1:0] rem_q;
	logic [cbt_pkg::S_W:0]   rsum, rsum_adj;
	logic                    carry, is_last, issue, adv, in_acc;

	cbt_pkg::sample_t smp;
	logic             out_vld;

	always_comb begin
		if (wr_data < cbt_pkg::CFG_W'(cbt_pkg::MIN_SAMPLES))
			n_new = cbt_pkg::N_W'(cbt_pkg::MIN_SAMPLES);
		else if (wr_data > cbt_pkg::CFG_W'(cbt_pkg::MAX_SAMPLES))
			n_new = cbt_pkg::N_W'(cbt_pkg::MAX_SAMPLES);
		else
			n_new = cbt_pkg::N_W'(wr_data);
	end

	// restoring divide of one (Q1.16) by the sample count
	assign div_bit = (cnt_q == cbt_pkg::DIVC_W'(cbt_pkg::FRAC));
	assign div_sh  = {drem_q, div_bit};
	assign div_ge  = ({1'b0, div_sh} >= {1'b0, n_q});
	assign div_rem = div_ge ? div_sh - n_q[cbt_pkg::S_W:0] : div_sh;
	assign quo_nxt = {quo_q[cbt_pkg::DIV_STEPS-2:0], div_ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q    <= cbt_pkg::N_W'(cbt_pkg::RESET_SAMPLES);
			q_q    <= cbt_pkg::T_W'(cbt_pkg::RESET_Q);
			r_q    <= cbt_pkg::S_W'(cbt_pkg::RESET_R);
			busy_q <= 1'b0;
			cnt_q  <= '0;
			drem_q <= '0;
			quo_q  <= '0;
		end else if (wr_en) begin
			n_q    <= n_new;
			busy_q <= 1'b1;
			cnt_q  <= cbt_pkg::DIVC_W'(cbt_pkg::FRAC);
			drem_q <= '0;
			quo_q  <= '0;
		end else if (busy_q) begin
			drem_q <= div_rem[cbt_pkg::S_W-1:0];
			quo_q  <= quo_nxt;
			cnt_q  <= cnt_q - cbt_pkg::DIVC_W'(1);
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				q_q    <= quo_nxt[cbt_pkg::T_W-1:0];
				r_q    <= div_rem[cbt_pkg::S_W-1:0];
			end
		end
	end

	assign adv     = !out_vld || point.ready;
	assign is_last = ({1'b0, s_q} == n_q - cbt_pkg::N_W'(1));
	assign issue   = seg_vld_q && adv;

	assign segment.ready = !busy_q && (!seg_vld_q || (adv && is_last));
	assign in_acc        = segment.valid && segment.ready;

	assign rsum     = {1'b0, rem_q} + {1'b0, r_q};
	assign carry    = ({1'b0, rsum} >= {1'b0, n_q});
	assign rsum_adj = carry ? rsum - n_q[cbt_pkg::S_W:0] : rsum;
	assign t_nxt    = t_q + q_q + cbt_pkg::T_W'(carry);
	assign u_nxt    = cbt_pkg::ONE_Q16 - {1'b0, t_nxt};

	always_comb begin
		seg_d.x[0] = segment.start_x;
		seg_d.x[1] = segment.handle_out_x;
		seg_d.x[2] = segment.handle_in_x;
		seg_d.x[3] = segment.end_x;
		seg_d.y[0] = segment.start_y;
		seg_d.y[1] = segment.handle_out_y;
		seg_d.y[2] = segment.handle_in_y;
		seg_d.y[3] = segment.end_y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_vld_q <= 1'b0;
			s_q       <= '0;
			t_q       <= '0;
			u_q       <= cbt_pkg::ONE_Q16;
			rem_q     <= '0;
		end else begin
			if (issue) begin
				if (is_last) begin
					s_q   <= '0;
					t_q   <= '0;
					u_q   <= cbt_pkg::ONE_Q16;
					rem_q <= '0;
				end else begin
					s_q   <= s_q + cbt_pkg::S_W'(1);
					t_q   <= t_nxt;
					u_q   <= u_nxt;
					rem_q <= rsum_adj[cbt_pkg::S_W-1:0];
				end
			end
			if (in_acc)
				seg_vld_q <= 1'b1;
			else if (issue && is_last)
				seg_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc)
			seg_q <= seg_d;
	end

	always_comb begin
		smp.last = is_last;
		smp.t    = t_q;
		smp.u    = u_q;
		smp.pts  = seg_q;
	end

	cbt_eval u_eval (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_vld   (seg_vld_q),
		.in_smp   (smp),
		.out_vld  (out_vld),
		.out_x    (point.point_x),
		.out_y    (point.point_y),
		.out_last (point.last_sample)
	);

	assign point.valid = out_vld;

endmodule

### hdl/cbt_checker.sv
// ----------------------------------------------------------------------------
// cbt_checker
// Port-level checks of the tessellator, bound to the top level.
// ----------------------------------------------------------------------------
module cbt_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            seg_valid,
	input logic            seg_ready,
	input logic            pt_valid,
	input logic            pt_ready,
	input cbt_pkg::coord_t pt_x,
	input cbt_pkg::coord_t pt_y,
	input logic            pt_last,
	input logic            wr_en
);

	a_pt_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pt_valid && !pt_ready |=> pt_valid)
		else $error("point valid dropped while stalled");

	a_pt_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		pt_valid && !pt_ready |=> $stable(pt_x) && $stable(pt_y) && $stable(pt_last))
		else $error("point payload changed while stalled");

	a_cfg_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> !seg_ready)
		else $error("segment taken while the sample step is recomputed");

	a_one_buffered: assert property (@(posedge clk) disable iff (!arst_n)
		(seg_valid && seg_ready && pt_valid && !pt_ready) ##1 (pt_valid && !pt_ready)
		|-> !seg_ready)
		else $error("second segment taken while the output stalls");

endmodule

bind cubic_bezier_tessellator cbt_checker u_cbt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.seg_valid (segment.valid),
	.seg_ready (segment.ready),
	.pt_valid  (point.valid),
	.pt_ready  (point.ready),
	.pt_x      (point.point_x),
	.pt_y      (point.point_y),
	.pt_last   (point.last_sample),
	.wr_en     (wr_en)
);

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the cubic Bezier tessellator.
// A queue-fed driver offers curve segments and a monitor takes sampled points.
// Every accepted segment is expanded into its expected points at the current
// sample count, and each point transaction is checked against the oldest one.
// The run covers fixed corner segments, then random segments under several
// sample counts (clamped extremes included) and several handshake patterns,
// with one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;

	localparam int PIPE_LATENCY  = 7;
	localparam int HOLD_CYCLES   = 600;
	localparam int SEGS_PER_STEP = 16;
	localparam int N_STEPS       = 9;

	typedef struct packed {
		cbt_pkg::coord_t x;
		cbt_pkg::coord_t y;
		logic            last;
	} point_t;

	logic                      clk;
	logic                      arst_n;
	logic                      wr_en;
	logic [cbt_pkg::CFG_W-1:0] wr_data;

	cbt_seg_if seg_ch ();
	cbt_pt_if  pt_ch ();

	cubic_bezier_tessellator DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.segment (seg_ch),
		.point   (pt_ch),
		.wr_en   (wr_en),
		.wr_data (wr_data)
	);

	cbt_pkg::seg_t pending_segs[$];
	point_t        expected_points[$];
	int unsigned   samples_cfg;
	int            idle_mode;
	logic          hold_request;
	logic          hold_off;
	int            mismatches;

	function automatic bit chance(int pct);
		return $urandom_range(99) < pct;
	endfunction

	function automatic int idle_pct(bit receiver);
		case (idle_mode)
			0: return receiver ? 82 : 26;
			1: return receiver ? 26 : 82;
			default: return 0;
		endcase
	endfunction

	function automatic cbt_pkg::coord_t blend(cbt_pkg::coord_t [3:0] p,
			longint unsigned w[4]);
		longint acc;
		acc = 0;
		for (int k = 0; k < 4; k++)
			acc += longint'($signed(p[k])) * longint'(w[k]);
		acc = acc >>> cbt_pkg::FRAC;
		if (acc > longint'(cbt_pkg::COORD_MAX))
			return cbt_pkg::COORD_MAX;
		if (acc < longint'(cbt_pkg::COORD_MIN))
			return cbt_pkg::COORD_MIN;
		return cbt_pkg::coord_t'(acc);
	endfunction

	function automatic void tessellate_segment(cbt_pkg::seg_t seg);
		int unsigned     n;
		longint unsigned t;
		longint unsigned u;
		longint unsigned w[4];
		point_t          pt;
		n = samples_cfg;
		if (n < cbt_pkg::MIN_SAMPLES)
			n = cbt_pkg::MIN_SAMPLES;
		if (n > cbt_pkg::MAX_SAMPLES)
			n = cbt_pkg::MAX_SAMPLES;
		for (int unsigned s = 0; s < n; s++) begin
			t = (64'(s) << cbt_pkg::FRAC) / n;
			u = (64'd1 << cbt_pkg::FRAC) - t;
			w[0] = (((u * u) >> cbt_pkg::FRAC) * u) >> cbt_pkg::FRAC;
			w[1] = (((3 * u * u) >> cbt_pkg::FRAC) * t) >> cbt_pkg::FRAC;
			w[2] = (((3 * u * t) >> cbt_pkg::FRAC) * t) >> cbt_pkg::FRAC;
			w[3] = (((t * t) >> cbt_pkg::FRAC) * t) >> cbt_pkg::FRAC;
			pt.x = blend(seg.x, w);
			pt.y = blend(seg.y, w);
			pt.last = (s == n - 1);
			expected_points.insert(expected_points.size(), pt);
		end
	endfunction

	function automatic void note_mismatch(string what, logic [31:0] want, logic [31:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
	endfunction

	function automatic void push_seg(cbt_pkg::coord_t x0, cbt_pkg::coord_t y0,
			cbt_pkg::coord_t x1, cbt_pkg::coord_t y1,
			cbt_pkg::coord_t x2, cbt_pkg::coord_t y2,
			cbt_pkg::coord_t x3, cbt_pkg::coord_t y3);
		cbt_pkg::seg_t seg;
		seg.x = {x3, x2, x1, x0};
		seg.y = {y3, y2, y1, y0};
		pending_segs.insert(pending_segs.size(), seg);
	endfunction

	function automatic cbt_pkg::coord_t random_coord(int kind);
		case (kind)
			0: return cbt_pkg::coord_t'($urandom);
			1: return cbt_pkg::coord_t'($signed($urandom_range(0, 2 ** 21)) - 2 ** 20);
			default: begin
				case ($urandom_range(4))
					0: return cbt_pkg::COORD_MAX;
					1: return cbt_pkg::COORD_MIN;
					2: return '0;
					3: return '1;
					default: return cbt_pkg::coord_t'($urandom);
				endcase
			end
		endcase
	endfunction

	function automatic cbt_pkg::seg_t random_segment();
		cbt_pkg::seg_t seg;
		int            r;
		int            kind;
		r = $urandom_range(99);
		kind = (r < 60) ? 0 : ((r < 85) ? 1 : 2);
		for (int k = 0; k < 4; k++) begin
			seg.x[k] = random_coord(kind);
			seg.y[k] = random_coord(kind);
		end
		return seg;
	endfunction

	task automatic wait_idle();
		while (pending_segs.size() != 0 || seg_ch.valid || expected_points.size() != 0)
			@(posedge clk);
		repeat (PIPE_LATENCY) @(posedge clk);
	endtask

	task automatic write_samples(int unsigned value);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_data <= value[cbt_pkg::CFG_W-1:0];
		@(posedge clk);
		wr_en <= 1'b0;
		samples_cfg = value;
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk or negedge arst_n) begin
		cbt_pkg::seg_t taken;
		cbt_pkg::seg_t nxt;
		if (!arst_n) begin
			seg_ch.valid <= 1'b0;
			seg_ch.start_x <= '0;
			seg_ch.start_y <= '0;
			seg_ch.handle_out_x <= '0;
			seg_ch.handle_out_y <= '0;
			seg_ch.handle_in_x <= '0;
			seg_ch.handle_in_y <= '0;
			seg_ch.end_x <= '0;
			seg_ch.end_y <= '0;
		end else begin
			if (seg_ch.valid && seg_ch.ready) begin
				taken.x = {seg_ch.end_x, seg_ch.handle_in_x, seg_ch.handle_out_x, seg_ch.start_x};
				taken.y = {seg_ch.end_y, seg_ch.handle_in_y, seg_ch.handle_out_y, seg_ch.start_y};
				tessellate_segment(taken);
			end
			if (!seg_ch.valid || seg_ch.ready) begin
				if (pending_segs.size() != 0 && !chance(idle_pct(1'b0))) begin
					nxt = pending_segs.pop_front();
					seg_ch.valid <= 1'b1;
					seg_ch.start_x <= nxt.x[0];
					seg_ch.start_y <= nxt.y[0];
					seg_ch.handle_out_x <= nxt.x[1];
					seg_ch.handle_out_y <= nxt.y[1];
					seg_ch.handle_in_x <= nxt.x[2];
					seg_ch.handle_in_y <= nxt.y[2];
					seg_ch.end_x <= nxt.x[3];
					seg_ch.end_y <= nxt.y[3];
				end else begin
					seg_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		point_t want;
		if (!arst_n) begin
			pt_ch.ready <= 1'b0;
		end else begin
			if (pt_ch.valid && pt_ch.ready) begin
				if (expected_points.size() == 0) begin
					note_mismatch("unexpected point x", 'x, pt_ch.point_x);
				end else begin
					want = expected_points.pop_front();
					if (pt_ch.point_x !== want.x)
						note_mismatch("point_x", want.x, pt_ch.point_x);
					if (pt_ch.point_y !== want.y)
						note_mismatch("point_y", want.y, pt_ch.point_y);
					if (pt_ch.last_sample !== want.last)
						note_mismatch("last_sample", 32'(want.last), 32'(pt_ch.last_sample));
				end
			end
			pt_ch.ready <= !hold_off && !chance(idle_pct(1'b1));
		end
	end

	initial begin
		hold_off = 1'b0;
		wait (hold_request);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		#10_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		int unsigned settings[N_STEPS];
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_data = '0;
		hold_request = 1'b0;
		mismatches = 0;
		samples_cfg = cbt_pkg::RESET_SAMPLES;
		idle_mode = 0;
		settings = '{0, cbt_pkg::MAX_SAMPLES, 1, 127, cbt_pkg::MIN_SAMPLES, 3,
			cbt_pkg::MAX_SAMPLES + 1, cbt_pkg::RESET_SAMPLES, 0};
		settings[N_STEPS-1] = $urandom_range(127);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		push_seg('0, '0, '0, '0, '0, '0, '0, '0);
		push_seg(cbt_pkg::COORD_MAX, cbt_pkg::COORD_MAX, cbt_pkg::COORD_MAX,
			cbt_pkg::COORD_MAX, cbt_pkg::COORD_MAX, cbt_pkg::COORD_MAX,
			cbt_pkg::COORD_MAX, cbt_pkg::COORD_MAX);
		push_seg(cbt_pkg::COORD_MIN, cbt_pkg::COORD_MIN, cbt_pkg::COORD_MIN,
			cbt_pkg::COORD_MIN, cbt_pkg::COORD_MIN, cbt_pkg::COORD_MIN,
			cbt_pkg::COORD_MIN, cbt_pkg::COORD_MIN);
		push_seg(cbt_pkg::COORD_MAX, cbt_pkg::COORD_MIN, cbt_pkg::COORD_MAX,
			cbt_pkg::COORD_MIN, cbt_pkg::COORD_MAX, cbt_pkg::COORD_MIN,
			cbt_pkg::COORD_MAX, cbt_pkg::COORD_MIN);
		push_seg(cbt_pkg::COORD_MAX, cbt_pkg::COORD_MIN, cbt_pkg::COORD_MIN,
			cbt_pkg::COORD_MAX, cbt_pkg::COORD_MIN, cbt_pkg::COORD_MAX,
			cbt_pkg::COORD_MAX, cbt_pkg::COORD_MIN);
		push_seg(cbt_pkg::COORD_MIN, cbt_pkg::COORD_MAX, cbt_pkg::COORD_MAX,
			cbt_pkg::COORD_MIN, cbt_pkg::COORD_MAX, cbt_pkg::COORD_MIN,
			cbt_pkg::COORD_MIN, cbt_pkg::COORD_MAX);
		push_seg('1, '1, '1, '1, '1, '1, '1, '1);
		push_seg(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
			32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
		push_seg(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
			32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
		push_seg('0, '0, 32'h0001_0000, 32'h0002_0000,
			32'h0003_0000, -32'sh0002_0000, 32'h0004_0000, '0);
		push_seg(cbt_pkg::COORD_MAX, cbt_pkg::COORD_MIN, '0, '0, '0, '0,
			cbt_pkg::COORD_MIN, cbt_pkg::COORD_MAX);
		push_seg(32'h0000_0001, 32'h8000_0001, 32'h0000_0001, 32'h8000_0001,
			32'h7FFF_FFFE, 32'hFFFF_FFFE, 32'h7FFF_FFFE, 32'hFFFF_FFFE);

		for (int step = 0; step < N_STEPS; step++) begin
			wait_idle();
			idle_mode = step / 3;
			write_samples(settings[step]);
			if (step == 1)
				hold_request = 1'b1;
			repeat (SEGS_PER_STEP) pending_segs.insert(pending_segs.size(), random_segment());
		end

		wait_idle();
		repeat (4 * PIPE_LATENCY) @(posedge clk);
		if (mismatches == 0 && expected_points.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
